// File: rtl/assert_macros.svh
// Assertion helper macros for the gamut clip checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge, disabled in reset.
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("check failed");
`endif

// File: rtl/rgbgc_pkg.sv
// ----------------------------------------------------------------------------
// rgbgc_pkg
// Shared constants and types of the hue preserving gamut clip.
// ----------------------------------------------------------------------------
package rgbgc_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W  = 20;
	localparam int OUT_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_CLIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIP = 2'd1;
	// S range: 3*20 bit signed -> 22 bit; 3*x: 22 bit; tn: 22 bit, td: 23 bit.
	localparam int S_W  = 23;
	localparam int R_W  = 25;
	localparam int QW   = 64;

	typedef enum logic [1:0] {
		CLS_PASS  = 2'd0,
		CLS_BLACK = 2'd1,
		CLS_WHITE = 2'd2,
		CLS_SCALE = 2'd3
	} cls_t;

	typedef struct packed {
		cls_t                    cls;
		logic signed [IN_W-1:0]  x0;
		logic signed [IN_W-1:0]  x1;
		logic signed [IN_W-1:0]  x2;
		logic signed [S_W-1:0]   s;
		logic signed [R_W-1:0]   n;
		logic signed [R_W-1:0]   d;
	} item_t;
endpackage

// File: rtl/rgbgc_front.sv
// ----------------------------------------------------------------------------
// rgbgc_front
// Accepts pixels, classifies them and selects the smallest scale ratio.
// Three registered stages with a valid/ready flow control per stage.
// ----------------------------------------------------------------------------
module rgbgc_front #(
	parameter int FRAC_BITS = rgbgc_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 ready,
	input  logic signed [rgbgc_pkg::IN_W-1:0]    red_in,
	input  logic signed [rgbgc_pkg::IN_W-1:0]    green_in,
	input  logic signed [rgbgc_pkg::IN_W-1:0]    blue_in,
	input  logic [rgbgc_pkg::OUT_W-1:0]          min_clip_q,
	input  logic [rgbgc_pkg::OUT_W-1:0]          max_clip_q,
	output logic                                 f_valid,
	input  logic                                 f_ready,
	output rgbgc_pkg::item_t                     f_item
);
	localparam int IW = rgbgc_pkg::IN_W;
	localparam int SW = rgbgc_pkg::S_W;
	localparam int RW = rgbgc_pkg::R_W;
	localparam int PW = 2 * RW;
	localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< FRAC_BITS;

	// stage 1: sum, limits, range flags
	logic               v_s1;
	logic signed [IW-1:0] x_s1 [3];
	logic signed [SW-1:0] s_s1, lo3_s1, hi3_s1;
	logic               in_s1;
	// stage 2: class and per-component ratios
	logic               v_s2;
	rgbgc_pkg::item_t   it_s2;
	logic signed [RW-1:0] tn_s2 [3], td_s2 [3];
	logic [2:0]         ok_s2;
	// stage 3: chosen ratio
	logic               v_s3;
	rgbgc_pkg::item_t   it_s3;

	logic adv1, adv2, adv3;
	assign adv3 = !v_s3 || f_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign ready = adv1;

	logic signed [IW-1:0] xin [3];
	assign xin[0] = red_in;
	assign xin[1] = green_in;
	assign xin[2] = blue_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++) x_s1[i] <= xin[i];
			s_s1   <= SW'(red_in) + SW'(green_in) + SW'(blue_in);
			lo3_s1 <= SW'(min_clip_q) * SW'(3);
			hi3_s1 <= SW'(max_clip_q) * SW'(3);
			in_s1  <= (SW'(red_in) >= 0) && (SW'(red_in) <= ONE_S)
				&& (SW'(green_in) >= 0) && (SW'(green_in) <= ONE_S)
				&& (SW'(blue_in) >= 0) && (SW'(blue_in) <= ONE_S);
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			it_s2.x0 <= x_s1[0];
			it_s2.x1 <= x_s1[1];
			it_s2.x2 <= x_s1[2];
			it_s2.s  <= s_s1;
			it_s2.n  <= RW'(1);
			it_s2.d  <= RW'(1);
			if (in_s1) it_s2.cls <= rgbgc_pkg::CLS_PASS;
			else if (s_s1 < lo3_s1) it_s2.cls <= rgbgc_pkg::CLS_BLACK;
			else if (s_s1 > hi3_s1) it_s2.cls <= rgbgc_pkg::CLS_WHITE;
			else it_s2.cls <= rgbgc_pkg::CLS_SCALE;
			for (int i = 0; i < 3; i++) begin
				if (SW'(x_s1[i]) > ONE_S) begin
					tn_s2[i] <= RW'(hi3_s1) - RW'(s_s1);
					td_s2[i] <= RW'(x_s1[i]) * RW'(3) - RW'(s_s1);
					ok_s2[i] <= (RW'(x_s1[i]) * RW'(3) - RW'(s_s1)) > 0;
				end else if (x_s1[i] < 0) begin
					tn_s2[i] <= RW'(s_s1) - RW'(lo3_s1);
					td_s2[i] <= RW'(s_s1) - RW'(x_s1[i]) * RW'(3);
					ok_s2[i] <= (RW'(s_s1) - RW'(x_s1[i]) * RW'(3)) > 0;
				end else begin
					tn_s2[i] <= '0;
					td_s2[i] <= RW'(1);
					ok_s2[i] <= 1'b0;
				end
			end
		end
	end

	// min over three candidates and 1/1; all cross products side by side
	always_ff @(posedge clk) begin
		logic signed [RW-1:0] cn [3];
		logic signed [RW-1:0] cd [3];
		logic [2:0] pick;
		logic signed [RW-1:0] n, d;
		rgbgc_pkg::item_t it;
		if (adv3) begin
			for (int i = 0; i < 3; i++) begin
				cn[i] = ok_s2[i] ? tn_s2[i] : RW'(1);
				cd[i] = ok_s2[i] ? td_s2[i] : RW'(1);
			end
			for (int i = 0; i < 3; i++) begin
				pick[i] = cn[i] < cd[i];
				for (int j = 0; j < 3; j++)
					if (j != i && (PW'(cn[i]) * PW'(cd[j]) > PW'(cn[j]) * PW'(cd[i])))
						pick[i] = 1'b0;
			end
			n = RW'(1);
			d = RW'(1);
			for (int i = 2; i >= 0; i--) begin
				if (pick[i]) begin
					n = cn[i];
					d = cd[i];
				end
			end
			it = it_s2;
			it.n = n;
			it.d = d;
			it_s3 <= it;
		end
	end

	assign f_valid = v_s3;
	assign f_item  = it_s3;
endmodule

// File: rtl/rgbgc_queue.sv
// ----------------------------------------------------------------------------
// rgbgc_queue
// Four-entry FIFO between classification and scaling.
// ----------------------------------------------------------------------------
module rgbgc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rgbgc_pkg::item_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output rgbgc_pkg::item_t out_item
);
	rgbgc_pkg::item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;
	assign in_ready  = cnt_q != 3'd4;
	assign out_valid = cnt_q != 3'd0;
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;
	assign out_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_item;
	end
endmodule

// File: rtl/rgbgc_back.sv
// ----------------------------------------------------------------------------
// rgbgc_back
// Applies the chosen scale: numerator build, pipelined division, rounding.
// The division is a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgbgc_back #(
	parameter int FRAC_BITS = rgbgc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           b_valid,
	output logic                           b_ready,
	input  rgbgc_pkg::item_t               b_item,
	output logic                           valid_o,
	input  logic                           ready_i,
	output logic [rgbgc_pkg::OUT_W-1:0]    red_out,
	output logic [rgbgc_pkg::OUT_W-1:0]    green_out,
	output logic [rgbgc_pkg::OUT_W-1:0]    blue_out
);
	localparam int RW = rgbgc_pkg::R_W;
	localparam int OW = rgbgc_pkg::OUT_W;
	localparam int NW = 52;           // numerator width
	localparam int QB = FRAC_BITS + 2; // quotient bits kept (saturates above)
	localparam int DW = RW + 2;
	localparam logic [OW-1:0] ONE_O = OW'(1) << FRAC_BITS;
	localparam int ST = QB + 2;

	typedef struct packed {
		rgbgc_pkg::cls_t cls;
		logic [2:0]      neg;
		logic [2:0]      big;
		logic [OW-1:0]   p0, p1, p2;
	} ctl_t;

	logic              v_q   [ST+1];
	ctl_t              c_q   [ST+1];
	logic [NW-1:0]     r_q   [ST+1][3];
	logic [DW-1:0]     den_q [ST+1];
	logic [QB-1:0]     qt_q  [ST+1][3];
	logic [ST:0]       adv;

	always_comb begin
		adv[ST] = !v_q[ST] || ready_i;
		for (int k = ST - 1; k >= 0; k--) adv[k] = !v_q[k] || adv[k+1];
	end
	assign b_ready = adv[0];

	// stage 0: products and numerators
	always_ff @(posedge clk) begin
		logic signed [NW-1:0] num;
		logic signed [RW-1:0] t;
		logic signed [rgbgc_pkg::IN_W-1:0] xs [3];
		if (adv[0]) begin
			xs[0] = b_item.x0;
			xs[1] = b_item.x1;
			xs[2] = b_item.x2;
			c_q[0].cls <= b_item.cls;
			c_q[0].p0 <= OW'(b_item.x0);
			c_q[0].p1 <= OW'(b_item.x1);
			c_q[0].p2 <= OW'(b_item.x2);
			den_q[0] <= DW'(b_item.d) * DW'(3);
			for (int i = 0; i < 3; i++) begin
				t = RW'(xs[i]) * RW'(3) - RW'(b_item.s);
				num = NW'(b_item.s) * NW'(b_item.d) + NW'(b_item.n) * NW'(t)
					+ NW'((DW'(b_item.d) * DW'(3)) >> 1);
				c_q[0].neg[i] <= (NW'(b_item.s) * NW'(b_item.d)
					+ NW'(b_item.n) * NW'(t)) < 0;
				r_q[0][i] <= num;
				qt_q[0][i] <= '0;
			end
			c_q[0].big <= '0;
		end
	end

	// quotient digit stages, MSB first; stage 1 catches overflow of kept bits
	for (genvar k = 0; k < ST; k++) begin : g_div
		always_ff @(posedge clk) begin
			logic [NW+QB-1:0] sh;
			ctl_t c;
			if (adv[k+1]) begin
				c = c_q[k];
				den_q[k+1] <= den_q[k];
				for (int i = 0; i < 3; i++) begin
					if (k == 0) begin
						sh = (NW+QB)'(den_q[k]) << QB;
						c.big[i] = (NW+QB)'(r_q[k][i]) >= sh;
						r_q[k+1][i] <= r_q[k][i];
						qt_q[k+1][i] <= '0;
					end else if (k <= QB) begin
						sh = (NW+QB)'(den_q[k]) << (QB - k);
						if ((NW+QB)'(r_q[k][i]) >= sh) begin
							r_q[k+1][i] <= NW'((NW+QB)'(r_q[k][i]) - sh);
							qt_q[k+1][i] <= qt_q[k][i] | (QB'(1) << (QB - k));
						end else begin
							r_q[k+1][i] <= r_q[k][i];
							qt_q[k+1][i] <= qt_q[k][i];
						end
					end else begin
						r_q[k+1][i] <= r_q[k][i];
						qt_q[k+1][i] <= qt_q[k][i];
					end
				end
				c_q[k+1] <= c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ST; k++) v_q[k] <= 1'b0;
		end else begin
			if (adv[0]) v_q[0] <= b_valid;
			for (int k = 0; k < ST; k++) if (adv[k+1]) v_q[k+1] <= v_q[k];
		end
	end

	function automatic logic [OW-1:0] fin(logic n, logic b, logic [QB-1:0] q);
		if (n) return '0;
		if (b || (QB'(q) > QB'(ONE_O))) return ONE_O;
		return OW'(q);
	endfunction

	logic [OW-1:0] o [3];
	always_comb begin
		for (int i = 0; i < 3; i++) o[i] = fin(c_q[ST].neg[i], c_q[ST].big[i], qt_q[ST][i]);
		case (c_q[ST].cls)
			rgbgc_pkg::CLS_PASS: begin
				red_out = c_q[ST].p0; green_out = c_q[ST].p1; blue_out = c_q[ST].p2;
			end
			rgbgc_pkg::CLS_BLACK: begin
				red_out = '0; green_out = '0; blue_out = '0;
			end
			rgbgc_pkg::CLS_WHITE: begin
				red_out = ONE_O; green_out = ONE_O; blue_out = ONE_O;
			end
			default: begin
				red_out = o[0]; green_out = o[1]; blue_out = o[2];
			end
		endcase
	end
	assign valid_o = v_q[ST];
endmodule

// File: rtl/rgb_gamut_clip_hue_preserving_core.sv
// ----------------------------------------------------------------------------
// rgb_gamut_clip_hue_preserving_core
// Gamut clip of signed RGB pixels preserving mean intensity and hue.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (red_in, green_in, blue_in) on valid/ready; results
//   (red_out, green_out, blue_out) on out_valid/out_ready.
//   Config words on cfg_valid/cfg_ready with cfg_index and cfg_data:
//   index 0 min_clip, index 1 max_clip; other indexes ignored.
//   Throughput: one word per cycle while out_ready stays high.
//   Pipeline: 3 front stages, the queue, then FRAC_BITS + 5 back
//   stages (numerator, overflow check, one divider stage per quotient
//   bit, output).
//   Reset clears all valid flags and loads min_clip 0, max_clip one.
//   When out_ready is low the pipeline and queue fill, then ready drops;
//   no word is lost.
// ----------------------------------------------------------------------------
module rgb_gamut_clip_hue_preserving_core #(
	parameter int FRAC_BITS = rgbgc_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 ready,
	input  logic signed [rgbgc_pkg::IN_W-1:0]    red_in,
	input  logic signed [rgbgc_pkg::IN_W-1:0]    green_in,
	input  logic signed [rgbgc_pkg::IN_W-1:0]    blue_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rgbgc_pkg::OUT_W-1:0]          red_out,
	output logic [rgbgc_pkg::OUT_W-1:0]          green_out,
	output logic [rgbgc_pkg::OUT_W-1:0]          blue_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rgbgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgbgc_pkg::OUT_W-1:0]          cfg_data
);
	logic [rgbgc_pkg::OUT_W-1:0] min_clip_q, max_clip_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_clip_q <= '0;
			max_clip_q <= rgbgc_pkg::OUT_W'(1) << FRAC_BITS;
		end else if (cfg_valid) begin
			case (cfg_index)
				rgbgc_pkg::REG_MIN_CLIP: min_clip_q <= cfg_data;
				rgbgc_pkg::REG_MAX_CLIP: max_clip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic fv, fr, bv, br;
	rgbgc_pkg::item_t fi, bi;

	rgbgc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .valid, .ready, .red_in, .green_in, .blue_in,
		.min_clip_q, .max_clip_q, .f_valid(fv), .f_ready(fr), .f_item(fi)
	);
	rgbgc_queue u_queue (
		.clk, .arst_n, .in_valid(fv), .in_ready(fr), .in_item(fi),
		.out_valid(bv), .out_ready(br), .out_item(bi)
	);
	rgbgc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .b_valid(bv), .b_ready(br), .b_item(bi),
		.valid_o(out_valid), .ready_i(out_ready), .red_out, .green_out, .blue_out
	);
endmodule

// File: rtl/rgbgc_checker.sv
// ----------------------------------------------------------------------------
// rgbgc_checker
// Port-level checks of the gamut clip core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rgbgc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] red_out,
	input logic [16:0] green_out,
	input logic [16:0] blue_out
);
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(red_out))
	`CHK_IMPL(a_r_rng, clk, arst_n, out_valid, red_out <= 17'h10000)
	`CHK_IMPL(a_g_rng, clk, arst_n, out_valid, green_out <= 17'h10000)
	`CHK_IMPL(a_b_rng, clk, arst_n, out_valid, blue_out <= 17'h10000)
endmodule

bind rgb_gamut_clip_hue_preserving_core rgbgc_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .red_out, .green_out, .blue_out
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams signed RGB pixels through the gamut clip core under several
// clip limit settings and idle patterns, and checks every result word
// against a predicted clip of the same pixel.
// ----------------------------------------------------------------------------
module testbench;
	typedef struct {
		logic [rgbgc_pkg::OUT_W-1:0] r;
		logic [rgbgc_pkg::OUT_W-1:0] g;
		logic [rgbgc_pkg::OUT_W-1:0] b;
	} pixel_t;

	class clip_scoreboard;
		longint min_c = 0;
		longint max_c = 65536;
		pixel_t pending_q[$];

		function logic [rgbgc_pkg::OUT_W-1:0] sat(longint v);
			if (v < 0) v = 0;
			if (v > 65536) v = 65536;
			return v[rgbgc_pkg::OUT_W-1:0];
		endfunction

		function pixel_t clip_pixel(logic signed [rgbgc_pkg::IN_W-1:0] r,
				logic signed [rgbgc_pkg::IN_W-1:0] g,
				logic signed [rgbgc_pkg::IN_W-1:0] b);
			longint x[3];
			longint s, lo3, hi3, n, d, tn, td, num, den, q;
			logic [rgbgc_pkg::OUT_W-1:0] o[3];
			bit in_gamut;
			bit skip;
			pixel_t p;
			x[0] = r;
			x[1] = g;
			x[2] = b;
			in_gamut = 1;
			n = 1;
			d = 1;
			for (int i = 0; i < 3; i++)
				if (x[i] < 0 || x[i] > 65536) in_gamut = 0;
			s = x[0] + x[1] + x[2];
			lo3 = 3 * min_c;
			hi3 = 3 * max_c;
			if (in_gamut) begin
				for (int i = 0; i < 3; i++) o[i] = sat(x[i]);
			end else if (s < lo3) begin
				for (int i = 0; i < 3; i++) o[i] = '0;
			end else if (s > hi3) begin
				for (int i = 0; i < 3; i++) o[i] = sat(longint'(65536));
			end else begin
				for (int i = 0; i < 3; i++) begin
					skip = 0;
					if (x[i] > 65536) begin
						tn = hi3 - s;
						td = 3 * x[i] - s;
					end else if (x[i] < 0) begin
						tn = s - lo3;
						td = s - 3 * x[i];
					end else begin
						skip = 1;
					end
					if (!skip && td > 0 && tn * d < n * td) begin
						n = tn;
						d = td;
					end
				end
				for (int i = 0; i < 3; i++) begin
					num = s * d + n * (3 * x[i] - s);
					den = 3 * d;
					if (num < 0) begin
						o[i] = '0;
					end else begin
						q = (num + den / 2) / den;
						o[i] = sat(q);
					end
				end
			end
			p.r = o[0];
			p.g = o[1];
			p.b = o[2];
			return p;
		endfunction

		function void note_pixel(logic signed [rgbgc_pkg::IN_W-1:0] r,
				logic signed [rgbgc_pkg::IN_W-1:0] g,
				logic signed [rgbgc_pkg::IN_W-1:0] b);
			pending_q.push_back(clip_pixel(r, g, b));
		endfunction

		// returns 0 when no word was expected
		function bit check_pixel(output pixel_t want);
			if (pending_q.size() == 0) return 0;
			want = pending_q.pop_front();
			return 1;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic valid = 0;
	logic ready;
	logic signed [rgbgc_pkg::IN_W-1:0] red_in = '0, green_in = '0, blue_in = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [rgbgc_pkg::OUT_W-1:0] red_out, green_out, blue_out;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [rgbgc_pkg::CFG_IDX_W-1:0] cfg_index = rgbgc_pkg::REG_MIN_CLIP;
	logic [rgbgc_pkg::OUT_W-1:0] cfg_data = '0;

	clip_scoreboard sb = new();
	int errors = 0;
	int n_sent = 0;
	int n_recv = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_cycles = 0;

	always #1 clk = ~clk;

	rgb_gamut_clip_hue_preserving_core DUT (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .ready(ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	task automatic report(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && valid && ready) begin
			sb.note_pixel(red_in, green_in, blue_in);
			n_sent++;
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			n_recv++;
			if (!sb.check_pixel(want))
				report("result word with nothing expected");
			else if (red_out !== want.r || green_out !== want.g || blue_out !== want.b)
				report($sformatf("got %0d %0d %0d want %0d %0d %0d",
					red_out, green_out, blue_out, want.r, want.g, want.b));
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_pixel(int r, int g, int b);
		while ($urandom_range(99) < send_idle) begin
			valid <= 0;
			@(posedge clk);
		end
		valid <= 1;
		red_in <= rgbgc_pkg::IN_W'(r);
		green_in <= rgbgc_pkg::IN_W'(g);
		blue_in <= rgbgc_pkg::IN_W'(b);
		do @(posedge clk); while (!ready);
	endtask

	task automatic drain();
		valid <= 0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [rgbgc_pkg::CFG_IDX_W-1:0] idx, int val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= rgbgc_pkg::OUT_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == rgbgc_pkg::REG_MIN_CLIP) sb.min_c = longint'(val);
		else sb.max_c = longint'(val);
	endtask

	function automatic int rand_comp(int kind);
		case (kind)
			0: return $urandom_range(65536);
			1: return int'($signed(rgbgc_pkg::IN_W'($urandom)));
			2: return int'($urandom_range(131072)) - 32768;
			default: return int'($urandom_range(200000)) - 65536;
		endcase
	endfunction

	initial begin
		#4_000_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int kind;
		int lim_lo[6];
		int lim_hi[6];
		lim_lo = '{0, 0, 20000, 131071, 65536, 0};
		lim_hi = '{65536, 131071, 45000, 0, 65536, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (5) @(posedge clk);

		// directed, reset limits
		send_pixel(0, 0, 0);
		send_pixel(65536, 65536, 65536);
		send_pixel(65536, 0, 32768);
		send_pixel(-524288, -524288, -524288);
		send_pixel(524287, 524287, 524287);
		send_pixel(524287, -524288, 0);
		send_pixel(-524288, 524287, 1000);
		send_pixel(70000, 30000, 10000);
		send_pixel(-5000, 40000, 60000);
		send_pixel(65537, 524287, 524287);
		send_pixel(-1, 0, 0);
		send_pixel(100000, -20000, 40000);
		send_pixel(65537, -1, 32768);
		drain();
		write_reg(rgbgc_pkg::REG_MIN_CLIP, 131071);
		write_reg(rgbgc_pkg::REG_MAX_CLIP, 131071);
		send_pixel(200000, 200000, 65537);
		send_pixel(65537, 524287, 524287);
		send_pixel(-1, 0, 0);
		send_pixel(524287, 524287, 524287);
		drain();
		write_reg(rgbgc_pkg::REG_MIN_CLIP, 40000);
		write_reg(rgbgc_pkg::REG_MAX_CLIP, 20000);
		send_pixel(100000, 0, 0);
		send_pixel(-10000, 65536, 65536);
		send_pixel(30000, 30000, -1);

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			if (ph < 6) begin
				write_reg(rgbgc_pkg::REG_MIN_CLIP, lim_lo[ph]);
				write_reg(rgbgc_pkg::REG_MAX_CLIP, lim_hi[ph]);
			end else begin
				write_reg(rgbgc_pkg::REG_MIN_CLIP, $urandom_range(65536));
				write_reg(rgbgc_pkg::REG_MAX_CLIP, $urandom_range(131071));
			end
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 80; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 80; end
				default: begin send_idle = 16; recv_stall = 16; end
			endcase
			for (int k = 0; k < 75; k++) begin
				if (ph == 4 && k == 10) hold_cycles = 300;
				if (ph == 7 && k == 30) begin
					valid <= 0;
					while (sb.pending() > 0) @(posedge clk);
				end
				kind = $urandom_range(3);
				send_pixel(rand_comp(kind), rand_comp(kind), rand_comp($urandom_range(3)));
			end
		end

		valid <= 0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("%0d pixels sent, %0d results checked over 15 limit settings", n_sent, n_recv);
		$display("idle patterns: none, sender, receiver, both; long output hold included");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/rgbgc_pkg.sv
rtl/rgbgc_front.sv
rtl/rgbgc_queue.sv
rtl/rgbgc_back.sv
rtl/rgb_gamut_clip_hue_preserving_core.sv
rtl/rgbgc_checker.sv
test/testbench.sv
